FILE: hw/rtl/psi_pkg.sv
// shared types and constants for the setpoint interpolator
package psi_pkg;
  localparam int MaxPoints = 16;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = 5;
  localparam int DayW = 16;
  localparam int ValW = 14;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 14;
  localparam int QDepth = 2;
  localparam int QPtrW = 1;
  // product of signed 15 bit delta and 16 bit offset
  localparam int ProdW = 31;
  localparam int MagW = ProdW - 1;
  localparam int StepW = $clog2(MagW + 1);

  localparam logic [CfgIdxW-1:0] CFG_POINT_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_MIN    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_MAX    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HUM_MIN     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HUM_MAX     = 3'd4;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // one job passed from the front to the back
  typedef struct packed {
    logic [ValW-1:0] t_lo;
    logic [ValW-1:0] t_hi;
    logic [ValW-1:0] h_lo;
    logic [ValW-1:0] h_hi;
    logic [DayW-1:0] num;
    logic [DayW-1:0] den;
    logic            den_neg;
    logic            interp;
    logic            fail;
  } psi_job_t;

  typedef struct packed {
    logic [ValW-1:0] temp_out;
    logic [ValW-1:0] humidity_out;
    logic            valid_res;
  } psi_res_t;

  typedef struct packed {
    logic [ValW-1:0] temp_min;
    logic [ValW-1:0] temp_max;
    logic [ValW-1:0] hum_min;
    logic [ValW-1:0] hum_max;
  } psi_lim_t;
endpackage

FILE: hw/rtl/psi_if.sv
// valid/ready channel interfaces for the setpoint interpolator
interface psi_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [3:0]                entry_index;
  logic [15:0]               day;
  logic [13:0]               entry_temp;
  logic [13:0]               entry_humidity;
  modport source (output valid, func, entry_index, day, entry_temp, entry_humidity,
                  input ready);
  modport sink (input valid, func, entry_index, day, entry_temp, entry_humidity,
                output ready);
endinterface

interface psi_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] temp_out;
  logic [13:0] humidity_out;
  logic        valid_res;
  modport source (output valid, temp_out, humidity_out, valid_res, input ready);
  modport sink (input valid, temp_out, humidity_out, valid_res, output ready);
endinterface

FILE: hw/rtl/profile_setpoint_interp.sv
// top level of the checkpoint setpoint interpolator
// usage:
//  in_ channel: one beat either writes a checkpoint (func 0: slot, day, temp,
//  humidity) or queries a day (func 1). writes give no result beat.
//  out_ channel: one beat per query with temperature, humidity and valid_res.
//  cfg_ port: write point_count and the four limits only while idle.
// timing:
//  a write beat leaves the front idle. a query walks the table one interval
//  per cycle in the front, then the back runs a multiply and a 30 step
//  restoring division for each target before the result beat. a clamped or
//  failed query skips the multiply and division.
//  the job queue lets the front search the next query while the back divides.
// reset: limits and point_count go to their defaults, the table is unknown
//  until written and must be loaded before it is queried.
// stalls: a result holds on out_ until taken; the queue then fills and the
//  front stops taking input beats.
module profile_setpoint_interp (
  input  logic                           clk,
  input  logic                           rst_n,
  psi_in_if.sink                         in_ch,
  psi_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [psi_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [psi_pkg::CfgDataW-1:0]   cfg_data
);
  import psi_pkg::*;

  logic [CntW-1:0] point_count_r;
  psi_lim_t        lim_r;
  logic            fj_valid, fj_ready, bj_valid, bj_ready;
  psi_job_t        fj, bj;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
      lim_r.temp_min <= ValW'(1000);
      lim_r.temp_max <= ValW'(4500);
      lim_r.hum_min  <= ValW'(3000);
      lim_r.hum_max  <= ValW'(9500);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POINT_COUNT: point_count_r <= cfg_data[CntW-1:0];
        CFG_TEMP_MIN:    lim_r.temp_min <= cfg_data[ValW-1:0];
        CFG_TEMP_MAX:    lim_r.temp_max <= cfg_data[ValW-1:0];
        CFG_HUM_MIN:     lim_r.hum_min  <= cfg_data[ValW-1:0];
        CFG_HUM_MAX:     lim_r.hum_max  <= cfg_data[ValW-1:0];
        default: ;
      endcase
    end
  end

  psi_front u_front (
    .clk, .rst_n, .in_ch, .point_count(point_count_r),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  psi_queue u_queue (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  psi_back u_back (
    .clk, .rst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .lim(lim_r), .out_ch
  );
endmodule

FILE: hw/rtl/psi_front.sv
// front end: checkpoint table, end clamps and interval search
module psi_front (
  input  logic                       clk,
  input  logic                       rst_n,
  psi_in_if.sink                     in_ch,
  input  logic [psi_pkg::CntW-1:0]   point_count,
  output logic                       job_valid,
  input  logic                       job_ready,
  output psi_pkg::psi_job_t          job
);
  import psi_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_ENDS = 4'b0010,
    F_SRCH = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  logic [DayW-1:0] days_r [MaxPoints];
  logic [ValW-1:0] temps_r [MaxPoints];
  logic [ValW-1:0] hums_r [MaxPoints];

  fstate_t state_r, state_nxt;
  logic [DayW-1:0] qday_r;
  logic [IdxW-1:0] last_r;
  logic [IdxW-1:0] i_r;
  logic [IdxW-1:0] lo_r;
  logic            found_r;
  psi_job_t        job_r;
  logic [CntW-1:0] n_sat;
  logic [IdxW-1:0] ip1;
  logic            hit;
  logic            lo_sel;
  logic [IdxW-1:0] lo_fin;
  logic [IdxW-1:0] lo_fin1;
  logic            dn_neg;

  assign in_ch.ready = (state_r == F_IDLE);
  assign job_valid = (state_r == F_PUSH);
  assign job = job_r;

  assign n_sat = (point_count > CntW'(MaxPoints)) ? CntW'(MaxPoints) : point_count;
  assign ip1 = i_r + IdxW'(1);
  assign hit = (qday_r >= days_r[i_r]) && (qday_r <= days_r[ip1]);
  assign lo_sel = !found_r && hit;
  assign lo_fin = found_r ? lo_r : (hit ? i_r : '0);
  assign lo_fin1 = lo_fin + IdxW'(1);
  assign dn_neg = (days_r[lo_fin1] < days_r[lo_fin]);

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && in_ch.func == FUNC_WRITE) begin
      days_r[in_ch.entry_index]  <= in_ch.day;
      temps_r[in_ch.entry_index] <= in_ch.entry_temp;
      hums_r[in_ch.entry_index]  <= in_ch.entry_humidity;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_ch.valid && in_ch.func == FUNC_QUERY) state_nxt = F_ENDS;
      F_ENDS: begin
        if (n_sat == '0 || qday_r <= days_r[0] || qday_r >= days_r[last_r]) begin
          state_nxt = F_PUSH;
        end else begin
          state_nxt = F_SRCH;
        end
      end
      F_SRCH: if (found_r || hit || ip1 == last_r) state_nxt = F_PUSH;
      F_PUSH: if (job_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        qday_r  <= in_ch.day;
        last_r  <= IdxW'(n_sat - CntW'(1));
        i_r     <= '0;
        found_r <= 1'b0;
        lo_r    <= '0;
      end
      F_ENDS: begin
        job_r.interp  <= 1'b0;
        job_r.num     <= '0;
        job_r.den     <= '0;
        job_r.den_neg <= 1'b0;
        job_r.fail    <= (n_sat == '0);
        if (qday_r <= days_r[0]) begin
          job_r.t_lo <= temps_r[0];
          job_r.h_lo <= hums_r[0];
        end else begin
          job_r.t_lo <= temps_r[last_r];
          job_r.h_lo <= hums_r[last_r];
        end
      end
      F_SRCH: begin
        if (lo_sel) begin
          lo_r    <= i_r;
          found_r <= 1'b1;
        end
        i_r           <= ip1;
        job_r.interp  <= 1'b1;
        job_r.t_lo    <= temps_r[lo_fin];
        job_r.t_hi    <= temps_r[lo_fin1];
        job_r.h_lo    <= hums_r[lo_fin];
        job_r.h_hi    <= hums_r[lo_fin1];
        job_r.num     <= qday_r - days_r[lo_fin];
        // unsorted fallback interval may run backwards
        job_r.den     <= dn_neg ? (days_r[lo_fin] - days_r[lo_fin1])
                                : (days_r[lo_fin1] - days_r[lo_fin]);
        job_r.den_neg <= dn_neg;
        job_r.fail    <= (days_r[lo_fin1] == days_r[lo_fin]);
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && !job_ready |=> job_valid && $stable(job))
    else $error("job changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != F_IDLE |-> !in_ch.ready)
    else $error("input taken while busy");
  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == F_SRCH |-> i_r < last_r)
    else $error("search past last interval");
`endif
endmodule

FILE: hw/rtl/psi_queue.sv
// short job queue between front and back
module psi_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  psi_pkg::psi_job_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output psi_pkg::psi_job_t rd_data
);
  import psi_pkg::*;

  psi_job_t           mem_r [QDepth];
  logic [QPtrW-1:0]   wp_r, rp_r;
  logic [QPtrW:0]     cnt_r;
  logic               push, pop;

  assign wr_ready = (cnt_r != (QPtrW+1)'(QDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QPtrW'(1);
      if (pop) rp_r <= rp_r + QPtrW'(1);
      cnt_r <= cnt_r + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPtrW+1)'(QDepth))
    else $error("queue overflow");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("count lost a push");
  a_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> wp_r == rp_r)
    else $error("pointers disagree when empty");
`endif
endmodule

FILE: hw/rtl/psi_back.sv
// back end: multiply, serial divide for both targets, limit check
module psi_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  psi_pkg::psi_job_t  job,
  input  psi_pkg::psi_lim_t  lim,
  psi_out_if.source          out_ch
);
  import psi_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MUL  = 5'b00010,
    B_DIV  = 5'b00100,
    B_FIN  = 5'b01000,
    B_OUT  = 5'b10000
  } bstate_t;

  bstate_t state_r, state_nxt;
  psi_job_t job_r;
  logic           sel_r;        // 0 temperature, 1 humidity
  logic           neg_r;
  logic [MagW-1:0] q_r;
  logic [DayW:0]   rem_r;
  logic [StepW-1:0] step_r;
  logic signed [ValW+1:0] base_r;
  logic signed [ProdW:0]  tval_r;
  psi_res_t res_r;
  logic [ValW-1:0] tkeep_r;
  logic            ok_t_s;

  logic signed [ValW:0]  delta;
  logic signed [ProdW-1:0] prod;
  logic [DayW:0]   trial;
  logic            take;
  logic            ok_t;
  logic            ok_h2, ok_te, ok_he;

  assign job_ready = (state_r == B_IDLE);
  assign out_ch.valid = (state_r == B_OUT);
  assign out_ch.temp_out = res_r.temp_out;
  assign out_ch.humidity_out = res_r.humidity_out;
  assign out_ch.valid_res = res_r.valid_res;

  assign delta = sel_r ? ($signed({1'b0, job_r.h_hi}) - $signed({1'b0, job_r.h_lo}))
                       : ($signed({1'b0, job_r.t_hi}) - $signed({1'b0, job_r.t_lo}));
  assign prod = delta * $signed({1'b0, job_r.num});
  assign trial = {rem_r[DayW-1:0], q_r[MagW-1]};
  assign take = trial >= {1'b0, job_r.den};
  assign ok_t = (tval_r >= $signed({1'b0, lim.temp_min})) &&
                (tval_r <= $signed({1'b0, lim.temp_max}));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (job_valid) state_nxt = (job.interp && !job.fail) ? B_MUL : B_FIN;
      B_MUL:  state_nxt = B_DIV;
      B_DIV:  if (step_r == StepW'(MagW - 1)) state_nxt = (sel_r || !job_r.interp) ? B_FIN
                                                                                   : B_MUL;
      B_FIN:  state_nxt = B_OUT;
      B_OUT:  if (out_ch.ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        job_r <= job;
        sel_r <= 1'b0;
        q_r   <= '0;
        base_r <= '0;
      end
      B_MUL: begin
        neg_r  <= prod[ProdW-1] ^ job_r.den_neg;
        q_r    <= prod[ProdW-1] ? MagW'(-prod) : MagW'(prod);
        rem_r  <= '0;
        step_r <= '0;
        base_r <= sel_r ? $signed({2'b00, job_r.h_lo}) : $signed({2'b00, job_r.t_lo});
      end
      B_DIV: begin
        q_r    <= {q_r[MagW-2:0], take};
        rem_r  <= take ? trial - {1'b0, job_r.den} : trial;
        step_r <= step_r + StepW'(1);
        if (step_r == StepW'(MagW - 1)) begin
          tval_r <= neg_r ? (ProdW+1)'(base_r) - (ProdW+1)'({1'b0, q_r[MagW-2:0], take})
                          : (ProdW+1)'(base_r) + (ProdW+1)'({1'b0, q_r[MagW-2:0], take});
          sel_r  <= 1'b1;
        end
      end
      B_FIN: begin
        if (job_r.interp) begin
          // tval_r holds humidity now when interpolating, temp kept aside
          res_r.valid_res    <= !job_r.fail && ok_t_s && ok_h2;
          res_r.temp_out     <= (!job_r.fail && ok_t_s && ok_h2) ? tkeep_r : '0;
          res_r.humidity_out <= (!job_r.fail && ok_t_s && ok_h2) ? ValW'(tval_r) : '0;
        end else begin
          res_r.valid_res    <= !job_r.fail && ok_te && ok_he;
          res_r.temp_out     <= (!job_r.fail && ok_te && ok_he) ? job_r.t_lo : '0;
          res_r.humidity_out <= (!job_r.fail && ok_te && ok_he) ? job_r.h_lo : '0;
        end
      end
      default: ;
    endcase
  end

  // temperature result captured after the first division
  always_ff @(posedge clk) begin
    if (state_r == B_MUL && sel_r) begin
      tkeep_r <= ValW'(tval_r);
      ok_t_s  <= ok_t;
    end
  end
  assign ok_h2 = (tval_r >= $signed({1'b0, lim.hum_min})) &&
                 (tval_r <= $signed({1'b0, lim.hum_max}));
  assign ok_te = (job_r.t_lo >= lim.temp_min) && (job_r.t_lo <= lim.temp_max);
  assign ok_he = (job_r.h_lo >= lim.hum_min) && (job_r.h_lo <= lim.hum_max);

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_r))
    else $error("result changed while stalled");
  a_zero_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.valid_res |-> out_ch.temp_out == '0 && out_ch.humidity_out == '0)
    else $error("invalid result carries data");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_DIV |-> job_r.den != '0)
    else $error("divide by zero interval");
`endif
endmodule

FILE: tb/tb_top.sv
// testbench for the checkpoint setpoint interpolator: directed and random tables and queries with a scoreboard
class setpoint_scoreboard;
  logic [15:0] days [16];
  logic [13:0] temps [16];
  logic [13:0] hums [16];
  logic [4:0]  count;
  logic [13:0] t_min, t_max, h_min, h_max;
  psi_pkg::psi_res_t targets_due [$];
  int unsigned errors;

  function new();
    count = 0;
    t_min = 1000;
    t_max = 4500;
    h_min = 3000;
    h_max = 9500;
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [13:0] data);
    case (idx)
      psi_pkg::CFG_POINT_COUNT: count = data[4:0];
      psi_pkg::CFG_TEMP_MIN:    t_min = data;
      psi_pkg::CFG_TEMP_MAX:    t_max = data;
      psi_pkg::CFG_HUM_MIN:     h_min = data;
      psi_pkg::CFG_HUM_MAX:     h_max = data;
      default: ;
    endcase
  endfunction

  function void note_beat(logic f, logic [3:0] slot, logic [15:0] day,
                          logic [13:0] et, logic [13:0] eh);
    int n;
    int lo;
    longint tv, hv, num, den;
    bit ok;
    psi_pkg::psi_res_t r;
    if (f == psi_pkg::FUNC_WRITE) begin
      days[slot] = day;
      temps[slot] = et;
      hums[slot] = eh;
      return;
    end
    n = (count > 16) ? 16 : count;
    ok = 1;
    tv = 0;
    hv = 0;
    if (n == 0) begin
      ok = 0;
    end else if (day <= days[0]) begin
      tv = temps[0];
      hv = hums[0];
    end else if (day >= days[n-1]) begin
      tv = temps[n-1];
      hv = hums[n-1];
    end else begin
      lo = 0;
      for (int i = 0; i + 1 < n; i++) begin
        if (day >= days[i] && day <= days[i+1]) begin
          lo = i;
          break;
        end
      end
      den = longint'(days[lo+1]) - longint'(days[lo]);
      num = longint'(day) - longint'(days[lo]);
      if (den == 0) begin
        ok = 0;
      end else begin
        tv = longint'(temps[lo]) + ((longint'(temps[lo+1]) - longint'(temps[lo])) * num) / den;
        hv = longint'(hums[lo]) + ((longint'(hums[lo+1]) - longint'(hums[lo])) * num) / den;
      end
    end
    if (ok && (tv < longint'(t_min) || tv > longint'(t_max))) ok = 0;
    if (ok && (hv < longint'(h_min) || hv > longint'(h_max))) ok = 0;
    r.temp_out = ok ? tv[13:0] : '0;
    r.humidity_out = ok ? hv[13:0] : '0;
    r.valid_res = ok;
    targets_due.push_back(r);
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_beat(psi_pkg::psi_res_t got);
    psi_pkg::psi_res_t want;
    if (targets_due.size() == 0) begin
      report($sformatf("unexpected result beat %p", got));
      return;
    end
    want = targets_due.pop_front();
    if (got.temp_out !== want.temp_out)
      report($sformatf("temp_out %0d want %0d", got.temp_out, want.temp_out));
    if (got.humidity_out !== want.humidity_out)
      report($sformatf("humidity_out %0d want %0d", got.humidity_out, want.humidity_out));
    if (got.valid_res !== want.valid_res)
      report($sformatf("valid_res %0b want %0b", got.valid_res, want.valid_res));
  endtask
endclass

module tb_top;
  import psi_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycles;
  logic [15:0] tbl_days [16];
  setpoint_scoreboard sb;

  psi_in_if in_ch();
  psi_out_if out_ch();

  profile_setpoint_interp u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("tb_top failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_beat('{out_ch.temp_out, out_ch.humidity_out, out_ch.valid_res});
  end

  task write_reg(logic [2:0] idx, logic [13:0] data);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task send_beat(logic f, logic [3:0] slot, logic [15:0] day, logic [13:0] et, logic [13:0] eh);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_ch.valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1;
    in_ch.func = f;
    in_ch.entry_index = slot;
    in_ch.day = day;
    in_ch.entry_temp = et;
    in_ch.entry_humidity = eh;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_beat(f, slot, day, et, eh);
  endtask

  task put_point(int slot, logic [15:0] day, logic [13:0] et, logic [13:0] eh);
    tbl_days[slot] = day;
    send_beat(FUNC_WRITE, slot[3:0], day, et, eh);
  endtask

  task ask(logic [15:0] day);
    send_beat(FUNC_QUERY, 4'($urandom), day, 14'($urandom), 14'($urandom));
  endtask

  task settle();
    @(negedge clk);
    in_ch.valid = 0;
    while (sb.targets_due.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task load_table(bit sorted);
    int d;
    d = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 20000);
    for (int s = 0; s < 16; s++) begin
      if (!sorted) d = $urandom_range(0, 65535);
      else if (s > 0 && $urandom_range(0, 9) != 0) d = d + $urandom_range(1, 4000);
      if (d > 65535) d = 65535;
      put_point(s, 16'(d), 14'($urandom_range(0, 10000)), 14'($urandom_range(0, 10000)));
    end
  endtask

  task pick_limits();
    int k;
    k = $urandom_range(0, 4);
    if (k < 2) begin
      write_reg(CFG_TEMP_MIN, 14'd0);
      write_reg(CFG_TEMP_MAX, 14'd10000);
      write_reg(CFG_HUM_MIN, 14'd0);
      write_reg(CFG_HUM_MAX, 14'd10000);
    end else begin
      write_reg(CFG_TEMP_MIN, 14'($urandom_range(0, 5000)));
      write_reg(CFG_TEMP_MAX, 14'($urandom_range(3000, 10000)));
      write_reg(CFG_HUM_MIN, 14'($urandom_range(0, 6000)));
      write_reg(CFG_HUM_MAX, k == 4 ? 14'd0 : 14'($urandom_range(4000, 10000)));
    end
  endtask

  initial begin
    int n, k, lim;
    sb = new();
    cycles = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 0;
    in_ch.func = FUNC_WRITE;
    in_ch.entry_index = '0;
    in_ch.day = '0;
    in_ch.entry_temp = '0;
    in_ch.entry_humidity = '0;
    out_ch.ready = 0;
    send_idle_pct = 27;
    recv_idle_pct = 48;
    repeat (8) @(negedge clk);
    rst_n = 1;

    // directed: extremes, empty table, flat interval, saturated count
    ask(16'd100);
    for (int s = 0; s < 16; s++)
      put_point(s, s == 15 ? 16'hffff : 16'(s * 4000),
                (s % 2) ? 14'd10000 : 14'd0, (s % 2) ? 14'd0 : 14'd10000);
    settle();
    write_reg(CFG_POINT_COUNT, 14'd16);
    write_reg(CFG_TEMP_MIN, 14'd0);
    write_reg(CFG_TEMP_MAX, 14'd10000);
    write_reg(CFG_HUM_MIN, 14'd0);
    write_reg(CFG_HUM_MAX, 14'd10000);
    ask(16'd0);
    ask(16'hffff);
    ask(16'd2001);
    ask(16'd59999);
    put_point(3, 16'd8000, 14'd5000, 14'd5000);
    ask(16'd8000);
    ask(16'd8001);
    settle();
    write_reg(CFG_POINT_COUNT, 14'd31);
    write_reg(CFG_TEMP_MIN, 14'd10000);
    write_reg(CFG_TEMP_MAX, 14'd0);
    ask(16'd30000);
    settle();
    write_reg(CFG_POINT_COUNT, 14'd1);
    write_reg(CFG_TEMP_MIN, 14'd0);
    write_reg(CFG_TEMP_MAX, 14'd10000);
    ask(16'd0);
    ask(16'd40000);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 48;
        recv_idle_pct = 27;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      k = $urandom_range(0, 9);
      n = (ph == 0) ? 0 : (ph == 1) ? 16 : (k < 6) ? $urandom_range(2, 16) : $urandom_range(0, 31);
      write_reg(CFG_POINT_COUNT, 14'(n));
      pick_limits();
      load_table($urandom_range(0, 4) != 0);
      lim = (n > 16) ? 16 : (n == 0 ? 1 : n);
      for (int q = 0; q < 55; q++) begin
        k = $urandom_range(0, 9);
        if (k == 0) begin
          put_point($urandom_range(0, 15), 16'($urandom), 14'($urandom_range(0, 10000)),
                    14'($urandom_range(0, 10000)));
        end else if (k < 3) begin
          ask(16'($urandom));
        end else begin
          int s;
          s = $urandom_range(0, lim - 1);
          if (s + 1 < lim && tbl_days[s+1] > tbl_days[s])
            ask(16'(tbl_days[s] + $urandom_range(0, tbl_days[s+1] - tbl_days[s])));
          else
            ask(tbl_days[s]);
        end
      end
      settle();
    end

    if (sb.errors == 0 && sb.targets_due.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end
endmodule

FILE: profile_setpoint_interp.f
hw/rtl/psi_pkg.sv
hw/rtl/psi_if.sv
hw/rtl/psi_front.sv
hw/rtl/psi_queue.sv
hw/rtl/psi_back.sv
hw/rtl/profile_setpoint_interp.sv
tb/tb_top.sv
